// ----- src/olist_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the ordered list engine.
// No dependencies; used by olist_cell and ordered_list_engine.
package olist_pkg;

   localparam int DATA_W   = 32;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Operation codes carried by a request transaction
   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD_FRONT    = 3'd0,
      OP_ADD_BACK     = 3'd1,
      OP_REMOVE_FRONT = 3'd2,
      OP_REMOVE_BACK  = 3'd3,
      OP_REMOVE_VALUE = 3'd4,
      OP_FIND         = 3'd5,
      OP_CLEAR        = 3'd6
   } opcode_type;

   // Status codes carried by a response transaction
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD       = 3'd0,
      CMD_MATCH      = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_PUSH_BACK  = 3'd3,
      CMD_POP_FRONT  = 3'd4,
      CMD_DELETE     = 3'd5
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type             cmd;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] first_value;
      logic signed [DATA_W-1:0] last_value;
   } rsp_type;

endpackage

// ----- src/olist_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one entry and its match flag.
// Depends on olist_pkg for the command struct.
module olist_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  olist_pkg::cell_ctrl_type            ctrl,
   input  logic [CNT_W-1:0]                    count,
   input  logic signed [olist_pkg::DATA_W-1:0] lower_data,
   input  logic signed [olist_pkg::DATA_W-1:0] upper_data,
   input  logic                                seen_in,
   input  logic signed [olist_pkg::DATA_W-1:0] tail_in,
   output logic signed [olist_pkg::DATA_W-1:0] data_out,
   output logic                                seen_out,
   output logic signed [olist_pkg::DATA_W-1:0] tail_out
);

   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

   logic signed [olist_pkg::DATA_W-1:0] data_ff, data_in;
   logic                                hit_ff, hit_in;
   logic                                occupied;
   logic                                is_tail;

   assign occupied = MY_IDX < count;
   assign is_tail  = count == MY_NEXT;

   // Pass the first-match mark and the tail value up the chain
   assign seen_out = seen_in | hit_ff;
   assign tail_out = tail_in | (is_tail ? data_ff : '0);
   assign data_out = data_ff;

   // Select the next entry from the broadcast command
   always_comb begin
      data_in = data_ff;
      hit_in  = hit_ff;
      unique case (ctrl.cmd)
         olist_pkg::CMD_MATCH: begin
            hit_in = occupied && (data_ff == ctrl.value);
         end
         olist_pkg::CMD_PUSH_FRONT: begin
            data_in = (IDX == 0) ? ctrl.value : lower_data;
         end
         olist_pkg::CMD_PUSH_BACK: begin
            if (count == MY_IDX) data_in = ctrl.value;
         end
         olist_pkg::CMD_POP_FRONT: begin
            data_in = upper_data;
         end
         olist_pkg::CMD_DELETE: begin
            if (seen_in || hit_ff) data_in = upper_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

endmodule

// ----- src/ordered_list_engine.sv -----
`timescale 1ns / 1ps
// A request is accepted in idle, then passes through match, update and report; its
// response is registered in report as soon as the response channel is free.
// A new request is taken only in idle, one transaction at a time, and a stalled response
// channel holds it longer. Storage is a chain of CAPACITY cells that shift with their
// neighbors in the update cycle. Reset (synchronous, active high) empties the list at once.
// A stalled response holds the next one in report; a new request is not taken meanwhile.
module ordered_list_engine #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  olist_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output olist_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_MATCH  = 4'b0010,
      S_UPDATE = 4'b0100,
      S_REPORT = 4'b1000
   } state_type;

   state_type                           state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [olist_pkg::OPCODE_W-1:0]      op_ff, op_in;
   logic signed [olist_pkg::DATA_W-1:0] value_ff, value_in;
   olist_pkg::status_type               status_ff, status_in;
   logic                                found_ff, found_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   olist_pkg::rsp_type                  rsp_ff, rsp_in;
   olist_pkg::cell_ctrl_type            ctrl;
   olist_pkg::cell_cmd_type             update_cmd;
   logic                                req_take;
   logic                                rsp_free;
   logic                                any_hit;
   logic [CNT_W+olist_pkg::COUNT_W-1:0] count_ext;

   logic signed [olist_pkg::DATA_W-1:0] data_w [CAPACITY];
   logic signed [olist_pkg::DATA_W-1:0] tail_w [CAPACITY+1];
   logic                                seen_w [CAPACITY+1];

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign any_hit   = seen_w[CAPACITY];
   assign count_ext = {{olist_pkg::COUNT_W{1'b0}}, count_ff};

   assign seen_w[0] = 1'b0;
   assign tail_w[0] = '0;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [olist_pkg::DATA_W-1:0] lower_data;
      logic signed [olist_pkg::DATA_W-1:0] upper_data;
      if (i == 0) begin : g_lo_end
         assign lower_data = ctrl.value;
      end else begin : g_lo_mid
         assign lower_data = data_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_hi_end
         assign upper_data = data_w[i];
      end else begin : g_hi_mid
         assign upper_data = data_w[i+1];
      end
      olist_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .count      (count_ff),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .seen_in    (seen_w[i]),
         .tail_in    (tail_w[i]),
         .data_out   (data_w[i]),
         .seen_out   (seen_w[i+1]),
         .tail_out   (tail_w[i+1])
      );
   end

   // Decide the list update once the match flags are in
   always_comb begin
      update_cmd = olist_pkg::CMD_HOLD;
      count_in   = count_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      if (state_ff == S_UPDATE) begin
         status_in = olist_pkg::STAT_OK;
         found_in  = 1'b0;
         unique case (op_ff)
            olist_pkg::OP_ADD_FRONT: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = olist_pkg::STAT_FULL;
               end else begin
                  update_cmd = olist_pkg::CMD_PUSH_FRONT;
                  count_in   = count_ff + 1'b1;
               end
            end
            olist_pkg::OP_ADD_BACK: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = olist_pkg::STAT_FULL;
               end else begin
                  update_cmd = olist_pkg::CMD_PUSH_BACK;
                  count_in   = count_ff + 1'b1;
               end
            end
            olist_pkg::OP_REMOVE_FRONT: begin
               if (count_ff == '0) begin
                  status_in = olist_pkg::STAT_EMPTY;
               end else begin
                  update_cmd = olist_pkg::CMD_POP_FRONT;
                  count_in   = count_ff - 1'b1;
               end
            end
            olist_pkg::OP_REMOVE_BACK: begin
               if (count_ff == '0) begin
                  status_in = olist_pkg::STAT_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            olist_pkg::OP_REMOVE_VALUE: begin
               if (count_ff == '0) begin
                  status_in = olist_pkg::STAT_EMPTY;
               end else if (any_hit) begin
                  update_cmd = olist_pkg::CMD_DELETE;
                  count_in   = count_ff - 1'b1;
                  found_in   = 1'b1;
               end else begin
                  status_in = olist_pkg::STAT_NOT_FOUND;
               end
            end
            olist_pkg::OP_FIND: begin
               if (any_hit) found_in = 1'b1;
               else status_in = olist_pkg::STAT_NOT_FOUND;
            end
            olist_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequence match, update and report
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctrl.cmd     = olist_pkg::CMD_HOLD;
      ctrl.value   = value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_data.opcode;
               value_in = req_data.value;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            ctrl.cmd = olist_pkg::CMD_MATCH;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            ctrl.cmd = update_cmd;
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.found       = found_ff;
               rsp_in.count       = count_ext[olist_pkg::COUNT_W-1:0];
               rsp_in.first_value = (count_ff == '0) ? '0 : data_w[0];
               rsp_in.last_value  = tail_w[CAPACITY];
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_accept_starts_match: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_MATCH)
      else $error("accepted request did not start a match");

   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_REPORT)
      else $error("response raised outside report");

   a_found_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.status == olist_pkg::STAT_OK)
      else $error("found flag with failing status");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_take)
      else $error("request taken while busy");
`endif

endmodule
